### rtl/rtpsm_pkg.sv
// Shared types and constants of the RTP flow sequence monitor.
package rtpsm_pkg;

   localparam int KEY_W   = 96;
   localparam int CSR_W   = 64;
   localparam int CSR_IDX_W = 2;
   localparam int STATUS_W = 3;
   localparam int DELTA_W = 17;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAYLOAD_TYPE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STATS_INTERVAL = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SDT_MAX_AGE = 2'd3;

   localparam logic [13:0] FRAME_LENGTH_RESET = 14'd1370;
   localparam logic [6:0]  PAYLOAD_TYPE_RESET = 7'd33;
   localparam logic [63:0] STATS_INTERVAL_RESET = 64'd5000000000;
   localparam logic [63:0] SDT_MAX_AGE_RESET = 64'd30000000000;

   localparam logic [STATUS_W-1:0] STATUS_IGNORED  = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_IN_ORDER = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_ROLLOVER = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_LOSS     = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_TS_FAULT = 3'd5;

   // +1 and -65535 in 17-bit two's complement
   localparam logic [DELTA_W-1:0] DELTA_ONE      = 17'h00001;
   localparam logic [DELTA_W-1:0] DELTA_ROLLOVER = 17'h10001;

   localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [63:0] window_start;
      logic [15:0] prev_seq;
      logic [31:0] pkt_counter;
      logic [31:0] err_counter;
      logic [63:0] sdt_time;
   } rec_type;

   typedef struct packed {
      logic capture;
      logic scan_start;
      logic scan_step;
      logic insert;
      logic load;
      logic calc;
      logic finish;
      logic fault;
      logic rsp_ignore;
      logic rsp_full;
   } cmd_type;

   typedef struct packed {
      logic pkt_match;
      logic scan_hit;
      logic scan_end;
      logic table_full;
      logic sync_ok;
   } stat_type;

endpackage

### rtl/rtpsm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rtpsm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/rtpsm_ctrl.sv
// Sequencer of the RTP flow sequence monitor.
module rtpsm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  rtpsm_pkg::stat_type stat,
   output rtpsm_pkg::cmd_type  cmd
);

   typedef enum logic [3:0] {
      IDLE, CHECK, SCAN, REC_RD, INSERT, LOAD, CALC, FINISH, FAULT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in = CHECK;
            end
         end
         CHECK: begin
            if (!stat.pkt_match) begin
               cmd.rsp_ignore = 1'b1;
               state_in = IDLE;
            end else begin
               cmd.scan_start = 1'b1;
               state_in = SCAN;
            end
         end
         SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_hit) begin
               state_in = REC_RD;
            end else if (stat.scan_end) begin
               if (stat.table_full) begin
                  cmd.rsp_full = 1'b1;
                  state_in = IDLE;
               end else begin
                  state_in = INSERT;
               end
            end
         end
         REC_RD: state_in = LOAD;
         INSERT: begin
            cmd.insert = 1'b1;
            state_in = LOAD;
         end
         LOAD: begin
            cmd.load = 1'b1;
            state_in = stat.sync_ok ? CALC : FAULT;
         end
         CALC: begin
            cmd.calc = 1'b1;
            state_in = FINISH;
         end
         FINISH: begin
            cmd.finish = 1'b1;
            state_in = IDLE;
         end
         FAULT: begin
            cmd.fault = 1'b1;
            state_in = IDLE;
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != IDLE);

endmodule

### rtl/rtpsm_dp.sv
// Datapath: registers, flow key search, flow records and result word.
module rtpsm_dp #(
   parameter int FLOW_SLOTS = 256
) (
   input  logic                    clock,
   input  logic                    reset,
   input  rtpsm_pkg::cmd_type      cmd,
   output rtpsm_pkg::stat_type     stat,
   input  logic                    csr_we,
   input  logic [rtpsm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rtpsm_pkg::CSR_W-1:0]     csr_wdata,
   input  logic [31:0]             req_src_ip,
   input  logic [31:0]             req_dst_ip,
   input  logic [15:0]             req_src_port,
   input  logic [15:0]             req_dst_port,
   input  logic [13:0]             req_frame_length,
   input  logic [6:0]              req_payload_kind,
   input  logic                    req_ts_sync_ok,
   input  logic                    req_sdt_seen,
   input  logic [15:0]             req_seq_number,
   input  logic [63:0]             req_arrival_time,
   output logic                    rsp_valid,
   output logic [2:0]              rsp_status,
   output logic signed [16:0]      rsp_seq_delta,
   output logic [7:0]              rsp_flow_slot,
   output logic [31:0]             rsp_error_count,
   output logic [31:0]             rsp_packet_count,
   output logic                    rsp_window_closed,
   output logic [31:0]             rsp_window_errors,
   output logic [31:0]             rsp_window_packets,
   output logic [63:0]             rsp_window_elapsed_ns,
   output logic                    rsp_sdt_expired
);

   localparam int SLOT_W = $clog2(FLOW_SLOTS);
   localparam int REC_W = $bits(rtpsm_pkg::rec_type);

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      sat_inc = (v == rtpsm_pkg::CNT_MAX) ? v : v + 32'd1;
   endfunction

   // configuration
   logic [13:0] frame_length_match_ff;
   logic [6:0]  payload_type_match_ff;
   logic [63:0] stats_interval_ff;
   logic [63:0] sdt_max_age_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_length_match_ff <= rtpsm_pkg::FRAME_LENGTH_RESET;
         payload_type_match_ff <= rtpsm_pkg::PAYLOAD_TYPE_RESET;
         stats_interval_ff <= rtpsm_pkg::STATS_INTERVAL_RESET;
         sdt_max_age_ff <= rtpsm_pkg::SDT_MAX_AGE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            rtpsm_pkg::CSR_FRAME_LENGTH: frame_length_match_ff <= csr_wdata[13:0];
            rtpsm_pkg::CSR_PAYLOAD_TYPE: payload_type_match_ff <= csr_wdata[6:0];
            rtpsm_pkg::CSR_STATS_INTERVAL: stats_interval_ff <= csr_wdata;
            rtpsm_pkg::CSR_SDT_MAX_AGE: sdt_max_age_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // captured request word
   logic [rtpsm_pkg::KEY_W-1:0] key_ff;
   logic [13:0] frame_length_ff;
   logic [6:0]  payload_kind_ff;
   logic        sync_ok_ff;
   logic        sdt_seen_ff;
   logic [15:0] seq_ff;
   logic [63:0] now_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         key_ff <= {req_src_ip, req_dst_ip, req_src_port, req_dst_port};
         frame_length_ff <= req_frame_length;
         payload_kind_ff <= req_payload_kind;
         sync_ok_ff <= req_ts_sync_ok;
         sdt_seen_ff <= req_sdt_seen;
         seq_ff <= req_seq_number;
         now_ff <= req_arrival_time;
      end
   end

   // flow key search, one entry a cycle over the filled slots
   logic [SLOT_W:0]   held_ff;
   logic [SLOT_W:0]   scan_idx_ff;
   logic [SLOT_W-1:0] cmp_idx_ff;
   logic              cmp_v_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic              fresh_ff;
   logic              issue;
   logic              hit;
   logic [rtpsm_pkg::KEY_W-1:0] key_rd;

   assign issue = (scan_idx_ff < held_ff);
   assign hit = cmp_v_ff && (key_rd == key_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
         cmp_v_ff <= 1'b0;
      end else begin
         if (cmd.scan_start) begin
            scan_idx_ff <= '0;
            cmp_v_ff <= 1'b0;
         end else if (cmd.scan_step) begin
            if (issue) begin
               scan_idx_ff <= scan_idx_ff + 1'b1;
            end
            cmp_v_ff <= issue;
            cmp_idx_ff <= scan_idx_ff[SLOT_W-1:0];
         end
         if (cmd.insert) begin
            held_ff <= held_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         fresh_ff <= 1'b0;
      end else if (cmd.insert) begin
         fresh_ff <= 1'b1;
      end
      if (cmd.scan_step && hit) begin
         slot_ff <= cmp_idx_ff;
      end else if (cmd.insert) begin
         slot_ff <= held_ff[SLOT_W-1:0];
      end
   end

   rtpsm_ram #(
      .WIDTH(rtpsm_pkg::KEY_W),
      .DEPTH(FLOW_SLOTS)
   ) u_key_ram (
      .clock  (clock),
      .wr_en  (cmd.insert),
      .wr_addr(held_ff[SLOT_W-1:0]),
      .wr_data(key_ff),
      .rd_addr(scan_idx_ff[SLOT_W-1:0]),
      .rd_data(key_rd)
   );

   assign stat.pkt_match = (frame_length_ff == frame_length_match_ff) &&
                           (payload_kind_ff == payload_type_match_ff);
   assign stat.scan_hit = hit;
   assign stat.scan_end = !issue && !cmp_v_ff;
   assign stat.table_full = (held_ff == (SLOT_W+1)'(FLOW_SLOTS));
   assign stat.sync_ok = sync_ok_ff;

   // flow record
   rtpsm_pkg::rec_type rec_ff, rec_rd, rec_wr;
   logic [REC_W-1:0]   rec_rd_bits;
   logic               rec_we;
   logic [63:0]        sdt_eff;

   rtpsm_ram #(
      .WIDTH(REC_W),
      .DEPTH(FLOW_SLOTS)
   ) u_rec_ram (
      .clock  (clock),
      .wr_en  (rec_we),
      .wr_addr(slot_ff),
      .wr_data(rec_wr),
      .rd_addr(slot_ff),
      .rd_data(rec_rd_bits)
   );

   assign rec_rd = rtpsm_pkg::rec_type'(rec_rd_bits);
   assign sdt_eff = sdt_seen_ff ? now_ff : rec_ff.sdt_time;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rec_ff <= fresh_ff ? '0 : rec_rd;
      end
   end

   // arithmetic stage
   logic [16:0] delta_ff;
   logic [63:0] age_ff;
   logic [63:0] sdt_age_ff;

   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         delta_ff <= {1'b0, seq_ff} - {1'b0, rec_ff.prev_seq};
         age_ff <= now_ff - rec_ff.window_start;
         sdt_age_ff <= now_ff - sdt_eff;
      end
   end

   // classification and counter update
   logic        close;
   logic        loss;
   logic [2:0]  seq_status;
   logic [31:0] err_step;
   logic [31:0] err_in;
   logic [31:0] pkt_in;

   always_comb begin
      close = (age_ff > stats_interval_ff);
      loss = 1'b0;
      if (delta_ff == rtpsm_pkg::DELTA_ONE) begin
         seq_status = rtpsm_pkg::STATUS_IN_ORDER;
      end else if (delta_ff == rtpsm_pkg::DELTA_ROLLOVER) begin
         seq_status = rtpsm_pkg::STATUS_ROLLOVER;
      end else begin
         seq_status = rtpsm_pkg::STATUS_LOSS;
         loss = 1'b1;
      end
      err_step = loss ? sat_inc(rec_ff.err_counter) : rec_ff.err_counter;
      if (close) begin
         err_in = '0;
         pkt_in = 32'd1;
      end else begin
         err_in = err_step;
         pkt_in = sat_inc(rec_ff.pkt_counter);
      end
      rec_wr = rec_ff;
      rec_wr.sdt_time = sdt_eff;
      rec_we = cmd.fault;
      if (cmd.finish) begin
         rec_we = 1'b1;
         rec_wr.prev_seq = seq_ff;
         rec_wr.pkt_counter = pkt_in;
         rec_wr.err_counter = err_in;
         if (close || fresh_ff) begin
            rec_wr.window_start = now_ff;
         end
      end
   end

   // result word
   logic              rsp_valid_ff;
   logic [2:0]        rsp_status_ff;
   logic [16:0]       rsp_delta_ff;
   logic [7:0]        rsp_slot_ff;
   logic [31:0]       rsp_err_ff;
   logic [31:0]       rsp_pkt_ff;
   logic              rsp_closed_ff;
   logic [31:0]       rsp_win_err_ff;
   logic [31:0]       rsp_win_pkt_ff;
   logic [63:0]       rsp_elapsed_ff;
   logic              rsp_expired_ff;
   logic [SLOT_W+7:0] slot_wide;

   assign slot_wide = {8'd0, slot_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.rsp_ignore | cmd.rsp_full | cmd.finish | cmd.fault;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_ignore || cmd.rsp_full) begin
         rsp_status_ff <= cmd.rsp_full ? rtpsm_pkg::STATUS_FULL : rtpsm_pkg::STATUS_IGNORED;
         rsp_delta_ff <= '0;
         rsp_slot_ff <= '0;
         rsp_err_ff <= '0;
         rsp_pkt_ff <= '0;
         rsp_closed_ff <= 1'b0;
         rsp_win_err_ff <= '0;
         rsp_win_pkt_ff <= '0;
         rsp_elapsed_ff <= '0;
         rsp_expired_ff <= 1'b0;
      end else if (cmd.fault) begin
         rsp_status_ff <= rtpsm_pkg::STATUS_TS_FAULT;
         rsp_delta_ff <= '0;
         rsp_slot_ff <= slot_wide[7:0];
         rsp_err_ff <= rec_ff.err_counter;
         rsp_pkt_ff <= rec_ff.pkt_counter;
         rsp_closed_ff <= 1'b0;
         rsp_win_err_ff <= '0;
         rsp_win_pkt_ff <= '0;
         rsp_elapsed_ff <= '0;
         rsp_expired_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_status_ff <= seq_status;
         rsp_delta_ff <= delta_ff;
         rsp_slot_ff <= slot_wide[7:0];
         rsp_err_ff <= err_in;
         rsp_pkt_ff <= pkt_in;
         rsp_closed_ff <= close;
         rsp_win_err_ff <= close ? err_step : '0;
         rsp_win_pkt_ff <= close ? rec_ff.pkt_counter : '0;
         rsp_elapsed_ff <= close ? age_ff : '0;
         rsp_expired_ff <= close && (sdt_age_ff > sdt_max_age_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_seq_delta = signed'(rsp_delta_ff);
   assign rsp_flow_slot = rsp_slot_ff;
   assign rsp_error_count = rsp_err_ff;
   assign rsp_packet_count = rsp_pkt_ff;
   assign rsp_window_closed = rsp_closed_ff;
   assign rsp_window_errors = rsp_win_err_ff;
   assign rsp_window_packets = rsp_win_pkt_ff;
   assign rsp_window_elapsed_ns = rsp_elapsed_ff;
   assign rsp_sdt_expired = rsp_expired_ff;

endmodule

### rtl/rtp_flow_sequence_monitor_core.sv
// Top level of the RTP flow sequence monitor.
//
// channel   ports                        handshake
// request   start, busy, req_*           taken when start and not busy
// result    rsp_valid, rsp_*             one-cycle strobe, cannot be held off
// config    csr_we, csr_index, csr_wdata written when csr_we is high
//
// A filtered-out word holds busy only in the check state. A known flow holds it through the
// search up to its slot and the read state, a new flow through a search of the held slots
// and the insert state, then both go through load, calc and finish. A full table searches
// all slots: the key search reads the key RAM one slot per cycle. A TS fault ends sooner. The
// result strobe comes in the first cycle with busy low, and the receiver cannot stall it.
// Synchronous reset; the fill count bounds the search, so keys and records need no clearing.
module rtp_flow_sequence_monitor_core #(
   parameter int FLOW_SLOTS = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [31:0]         req_src_ip,
   input  logic [31:0]         req_dst_ip,
   input  logic [15:0]         req_src_port,
   input  logic [15:0]         req_dst_port,
   input  logic [13:0]         req_frame_length,
   input  logic [6:0]          req_payload_kind,
   input  logic                req_ts_sync_ok,
   input  logic                req_sdt_seen,
   input  logic [15:0]         req_seq_number,
   input  logic [63:0]         req_arrival_time,
   output logic                rsp_valid,
   output logic [2:0]          rsp_status,
   output logic signed [16:0]  rsp_seq_delta,
   output logic [7:0]          rsp_flow_slot,
   output logic [31:0]         rsp_error_count,
   output logic [31:0]         rsp_packet_count,
   output logic                rsp_window_closed,
   output logic [31:0]         rsp_window_errors,
   output logic [31:0]         rsp_window_packets,
   output logic [63:0]         rsp_window_elapsed_ns,
   output logic                rsp_sdt_expired,
   input  logic                csr_we,
   input  logic [rtpsm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rtpsm_pkg::CSR_W-1:0]     csr_wdata
);

   rtpsm_pkg::cmd_type  cmd;
   rtpsm_pkg::stat_type stat;

   rtpsm_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy (busy),
      .stat (stat),
      .cmd  (cmd)
   );

   rtpsm_dp #(
      .FLOW_SLOTS(FLOW_SLOTS)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_src_ip           (req_src_ip),
      .req_dst_ip           (req_dst_ip),
      .req_src_port         (req_src_port),
      .req_dst_port         (req_dst_port),
      .req_frame_length     (req_frame_length),
      .req_payload_kind     (req_payload_kind),
      .req_ts_sync_ok       (req_ts_sync_ok),
      .req_sdt_seen         (req_sdt_seen),
      .req_seq_number       (req_seq_number),
      .req_arrival_time     (req_arrival_time),
      .rsp_valid            (rsp_valid),
      .rsp_status           (rsp_status),
      .rsp_seq_delta        (rsp_seq_delta),
      .rsp_flow_slot        (rsp_flow_slot),
      .rsp_error_count      (rsp_error_count),
      .rsp_packet_count     (rsp_packet_count),
      .rsp_window_closed    (rsp_window_closed),
      .rsp_window_errors    (rsp_window_errors),
      .rsp_window_packets   (rsp_window_packets),
      .rsp_window_elapsed_ns(rsp_window_elapsed_ns),
      .rsp_sdt_expired      (rsp_sdt_expired)
   );

`ifndef SYNTHESIS
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("accepted word did not start work");

   a_ignored_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == rtpsm_pkg::STATUS_IGNORED ||
                     rsp_status == rtpsm_pkg::STATUS_FULL)) |->
      (rsp_flow_slot == '0 && rsp_packet_count == '0 && !rsp_window_closed))
      else $error("ignored or table-full result carries data");
`endif

endmodule
